// File: rtl/rti_pkg.sv
// Shared widths, register indexes and pipeline payload types for the
// ray/triangle intersection pipeline. No dependencies.
package rti_pkg;

	localparam int CW     = 32;           // coordinate and direction width
	localparam int EW     = CW + 1;       // edge and offset vectors
	localparam int PQW    = CW + EW;      // dir times edge product
	localparam int PRW    = 2 * EW;       // edge times edge product
	localparam int QW     = PQW + 1;      // q = dir x e2
	localparam int RW     = PRW + 1;      // r = s x e1
	localparam int XW     = EW + 1;       // left dot operand, common width
	localparam int YW     = RW;           // right dot operand, common width
	localparam int SPLIT  = 33;           // low part of the right operand
	localparam int PW     = XW + (YW - SPLIT);
	localparam int DOTW   = 102;          // exact dot product width
	localparam int FRAC   = 16;           // fraction bits of the distance
	localparam int DISTW  = 31;           // distance width
	localparam int NDIV   = DISTW;        // one quotient bit per divider step
	localparam int SATSH  = DISTW - FRAC; // t at or above 2^SATSH saturates
	localparam int AW     = 4;            // APB address width
	localparam int NDOT   = 4;

	localparam logic [DISTW-1:0] DIST_MAX = '1;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_DIR_X = 2'd0;
	localparam logic [1:0] REG_DIR_Y = 2'd1;
	localparam logic [1:0] REG_DIR_Z = 2'd2;
	localparam logic [1:0] REG_EPS   = 2'd3;

	// Slots of the four dot products.
	localparam int DOT_A  = 0;
	localparam int DOT_NU = 1;
	localparam int DOT_NV = 2;
	localparam int DOT_NT = 3;

	typedef struct packed {
		logic [NDOT-1:0][2:0][XW-1:0] x;
		logic [NDOT-1:0][2:0][YW-1:0] y;
	} dot_in_t;

	typedef struct packed {
		logic [NDOT-1:0][DOTW-1:0] d;
	} dot_out_t;

	typedef struct packed {
		logic             miss;
		logic             sat;
		logic [DOTW-1:0]  den;
		logic [DOTW-1:0]  rem;
		logic [NDIV-1:0]  bits;
		logic [NDIV-1:0]  quo;
	} div_t;

endpackage

// File: rtl/rti_front.sv
// Front end: edge vectors, then the two cross products q and r, three stages.
// Depends on rti_pkg.
module rti_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [3:0][2:0][rti_pkg::CW-1:0]  pts,
	input  logic [2:0][rti_pkg::CW-1:0]       dir,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rti_pkg::dot_in_t                  out_data
);
	import rti_pkg::*;

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	logic [EW-1:0]  e1_d [3];
	logic [EW-1:0]  e2_d [3];
	logic [EW-1:0]  s_d  [3];
	logic [EW-1:0]  e1_s1 [3];
	logic [EW-1:0]  e2_s1 [3];
	logic [EW-1:0]  s_s1  [3];
	logic [EW-1:0]  e1_s2 [3];
	logic [EW-1:0]  e2_s2 [3];
	logic [EW-1:0]  s_s2  [3];
	logic [PQW-1:0] qpos_d [3];
	logic [PQW-1:0] qneg_d [3];
	logic [PRW-1:0] rpos_d [3];
	logic [PRW-1:0] rneg_d [3];
	logic [PQW-1:0] qpos_s2 [3];
	logic [PQW-1:0] qneg_s2 [3];
	logic [PRW-1:0] rpos_s2 [3];
	logic [PRW-1:0] rneg_s2 [3];
	logic [QW-1:0]  q_d [3];
	logic [RW-1:0]  r_d [3];
	dot_in_t        dot_d;
	dot_in_t        out_s3;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			e1_d[j] = EW'($signed(pts[2][j])) - EW'($signed(pts[1][j]));
			e2_d[j] = EW'($signed(pts[3][j])) - EW'($signed(pts[1][j]));
			s_d[j]  = EW'($signed(pts[0][j])) - EW'($signed(pts[1][j]));
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_cross
		localparam int I1 = (c + 1) % 3;
		localparam int I2 = (c + 2) % 3;
		assign qpos_d[c] = $signed(dir[I1]) * $signed(e2_s1[I2]);
		assign qneg_d[c] = $signed(dir[I2]) * $signed(e2_s1[I1]);
		assign rpos_d[c] = $signed(s_s1[I1]) * $signed(e1_s1[I2]);
		assign rneg_d[c] = $signed(s_s1[I2]) * $signed(e1_s1[I1]);
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			q_d[c] = QW'($signed(qpos_s2[c])) - QW'($signed(qneg_s2[c]));
			r_d[c] = RW'($signed(rpos_s2[c])) - RW'($signed(rneg_s2[c]));
			dot_d.x[DOT_A][c]  = XW'($signed(e1_s2[c]));
			dot_d.y[DOT_A][c]  = YW'($signed(q_d[c]));
			dot_d.x[DOT_NU][c] = XW'($signed(s_s2[c]));
			dot_d.y[DOT_NU][c] = YW'($signed(q_d[c]));
			dot_d.x[DOT_NV][c] = XW'($signed(dir[c]));
			dot_d.y[DOT_NV][c] = r_d[c];
			dot_d.x[DOT_NT][c] = XW'($signed(e2_s2[c]));
			dot_d.y[DOT_NT][c] = r_d[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			e1_s1 <= e1_d;
			e2_s1 <= e2_d;
			s_s1  <= s_d;
		end
		if (en2) begin
			e1_s2   <= e1_s1;
			e2_s2   <= e2_s1;
			s_s2    <= s_s1;
			qpos_s2 <= qpos_d;
			qneg_s2 <= qneg_d;
			rpos_s2 <= rpos_d;
			rneg_s2 <= rneg_d;
		end
		if (en3) out_s3 <= dot_d;
	end

	assign out_valid = vld_s3;
	assign out_data  = out_s3;

endmodule

// File: rtl/rti_dot.sv
// Four exact dot products: split partial products, recombine, sum.
// Depends on rti_pkg.
module rti_dot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rti_pkg::dot_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rti_pkg::dot_out_t  out_data
);
	import rti_pkg::*;

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	logic signed [PW-1:0]   pl_d  [NDOT][3];
	logic signed [PW-1:0]   ph_d  [NDOT][3];
	logic signed [PW-1:0]   pl_s1 [NDOT][3];
	logic signed [PW-1:0]   ph_s1 [NDOT][3];
	logic signed [DOTW-1:0] term_d  [NDOT][3];
	logic signed [DOTW-1:0] term_s2 [NDOT][3];
	dot_out_t               sum_d;
	dot_out_t               out_s3;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	// The wide operand is cut into an unsigned low part and a signed high part.
	for (genvar k = 0; k < NDOT; k++) begin : g_dot
		for (genvar c = 0; c < 3; c++) begin : g_comp
			assign pl_d[k][c] = $signed(in_data.x[k][c]) *
			                    $signed({1'b0, in_data.y[k][c][SPLIT-1:0]});
			assign ph_d[k][c] = $signed(in_data.x[k][c]) *
			                    $signed(in_data.y[k][c][YW-1:SPLIT]);
			assign term_d[k][c] = (DOTW'(ph_s1[k][c]) <<< SPLIT) + DOTW'(pl_s1[k][c]);
		end
		assign sum_d.d[k] = term_s2[k][0] + term_s2[k][1] + term_s2[k][2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pl_s1 <= pl_d;
			ph_s1 <= ph_d;
		end
		if (en2) term_s2 <= term_d;
		if (en3) out_s3 <= sum_d;
	end

	assign out_valid = vld_s3;
	assign out_data  = out_s3;

endmodule

// File: rtl/rti_div_step.sv
// One restoring division step: one quotient bit per stage.
// Depends on rti_pkg.
module rti_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rti_pkg::div_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rti_pkg::div_t  out_data
);
	import rti_pkg::*;

	logic            vld_s1;
	div_t            dat_s1;
	div_t            nxt;
	logic [DOTW:0]   trial;
	logic [DOTW:0]   diff;
	logic            ge;

	assign in_ready = !vld_s1 || out_ready;

	always_comb begin
		trial = {in_data.rem, in_data.bits[NDIV-1]};
		diff  = trial - {1'b0, in_data.den};
		ge    = trial >= {1'b0, in_data.den};
		nxt      = in_data;
		nxt.rem  = ge ? diff[DOTW-1:0] : trial[DOTW-1:0];
		nxt.bits = {in_data.bits[NDIV-2:0], 1'b0};
		nxt.quo  = {in_data.quo[NDIV-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) dat_s1 <= nxt;
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data.quo))
		else $error("divider step dropped a stalled transaction");

endmodule

// File: rtl/rti_test.sv
// Hit tests on the exact numerators, then a chain of divider steps for t.
// Depends on rti_pkg and rti_div_step.
module rti_test (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rti_pkg::CW-1:0]   eps,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  rti_pkg::dot_out_t        in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_hit,
	output logic [rti_pkg::DISTW-1:0] out_distance
);
	import rti_pkg::*;

	logic en1, en2, en3;
	logic vld_s1, vld_s2, vld_s3;

	logic [DOTW-1:0]        mag_d  [NDOT];
	logic [DOTW-1:0]        mag_s1 [NDOT];
	logic [DOTW-1:0]        a_v, nu_v, nv_v, nt_v;
	logic signed [DOTW:0]   uv_sum;
	logic                   nt_pos;
	logic                   miss;
	div_t                   init_d;
	div_t                   init_s2;
	logic                   link_valid [NDIV+1];
	logic                   link_ready [NDIV+1];
	div_t                   link_data  [NDIV+1];
	logic                   hit_s3;
	logic [DISTW-1:0]       dist_s3;

	assign en1      = !vld_s1 || en2;
	assign en2      = !vld_s2 || link_ready[0];
	assign en3      = !vld_s3 || out_ready;
	assign in_ready = en1;

	// A negative determinant flips all four values, which leaves u, v and t alone.
	always_comb begin
		for (int k = 0; k < NDOT; k++) begin
			mag_d[k] = in_data.d[DOT_A][DOTW-1] ? (~in_data.d[k] + 1'b1) : in_data.d[k];
		end
	end

	always_comb begin
		a_v    = mag_s1[DOT_A];
		nu_v   = mag_s1[DOT_NU];
		nv_v   = mag_s1[DOT_NV];
		nt_v   = mag_s1[DOT_NT];
		uv_sum = (DOTW+1)'($signed(nu_v)) + (DOTW+1)'($signed(nv_v));
		nt_pos = !nt_v[DOTW-1] && (nt_v != '0);
		miss   = (a_v == '0) || (a_v < DOTW'(eps)) || nu_v[DOTW-1] || nv_v[DOTW-1] ||
		         (uv_sum > $signed({1'b0, a_v})) || !nt_pos;
		init_d.miss = miss;
		init_d.sat  = {{SATSH{1'b0}}, nt_v} >= {a_v, {SATSH{1'b0}}};
		init_d.den  = a_v;
		init_d.rem  = {{SATSH{1'b0}}, nt_v[DOTW-1:SATSH]};
		init_d.bits = {nt_v[SATSH-1:0], {FRAC{1'b0}}};
		init_d.quo  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= link_valid[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) mag_s1 <= mag_d;
		if (en2) init_s2 <= init_d;
		if (en3) begin
			hit_s3  <= !link_data[NDIV].miss;
			dist_s3 <= link_data[NDIV].miss ? '0 :
			           (link_data[NDIV].sat ? DIST_MAX : link_data[NDIV].quo);
		end
	end

	assign link_valid[0]    = vld_s2;
	assign link_data[0]     = init_s2;
	assign link_ready[NDIV] = en3;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		rti_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	assign out_valid    = vld_s3;
	assign out_hit      = hit_s3;
	assign out_distance = dist_s3;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_hit |-> out_distance == '0)
		else $error("miss reported with a nonzero distance");

endmodule

// File: rtl/ray_triangle_intersection.sv
// Top level of the ray/triangle intersection pipeline: APB registers and
// the chain rti_front -> rti_dot -> rti_test. Depends on rti_pkg.
//
//  channel   handshake                    payload
//  item      item_valid / item_ready      origin_*, first_*, second_*, third_*
//  result    result_valid / result_ready  hit, distance
//  config    psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// One transaction enters per cycle while the result channel is not stalled; the stages are
// 3 front, 3 dot, 2 test, 31 divider steps and 1 output register, one quotient bit per divider stage.
// Every stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up while the output is stalled and nothing is lost.
// Reset clears all valid bits and loads the direction and epsilon defaults.
module ray_triangle_intersection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [rti_pkg::CW-1:0]        origin_x,
	input  logic [rti_pkg::CW-1:0]        origin_y,
	input  logic [rti_pkg::CW-1:0]        origin_z,
	input  logic [rti_pkg::CW-1:0]        first_x,
	input  logic [rti_pkg::CW-1:0]        first_y,
	input  logic [rti_pkg::CW-1:0]        first_z,
	input  logic [rti_pkg::CW-1:0]        second_x,
	input  logic [rti_pkg::CW-1:0]        second_y,
	input  logic [rti_pkg::CW-1:0]        second_z,
	input  logic [rti_pkg::CW-1:0]        third_x,
	input  logic [rti_pkg::CW-1:0]        third_y,
	input  logic [rti_pkg::CW-1:0]        third_z,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          hit,
	output logic [rti_pkg::DISTW-1:0]     distance,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rti_pkg::AW-1:0]        paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import rti_pkg::*;

	logic [2:0][CW-1:0]       dir_q;
	logic [31:0]              eps_q;
	logic [3:0][2:0][CW-1:0]  pts;
	logic                     wr_en;
	logic                     f_valid, f_ready, d_valid, d_ready;
	dot_in_t                  f_data;
	dot_out_t                 d_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q[0] <= 32'd655360;
			dir_q[1] <= 32'd0;
			dir_q[2] <= 32'd0;
			eps_q    <= 32'd281474977;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DIR_X: dir_q[0] <= pwdata;
				REG_DIR_Y: dir_q[1] <= pwdata;
				REG_DIR_Z: dir_q[2] <= pwdata;
				REG_EPS:   eps_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIR_X: prdata = dir_q[0];
			REG_DIR_Y: prdata = dir_q[1];
			REG_DIR_Z: prdata = dir_q[2];
			REG_EPS:   prdata = eps_q;
			default:   prdata = '0;
		endcase
	end

	assign pts[0] = {origin_z, origin_y, origin_x};
	assign pts[1] = {first_z, first_y, first_x};
	assign pts[2] = {second_z, second_y, second_x};
	assign pts[3] = {third_z, third_y, third_x};

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.pts       (pts),
		.dir       (dir_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	rti_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_data  (d_data)
	);

	rti_test u_test (
		.clk          (clk),
		.arst_n       (arst_n),
		.eps          (eps_q),
		.in_valid     (d_valid),
		.in_ready     (d_ready),
		.in_data      (d_data),
		.out_valid    (result_valid),
		.out_ready    (result_ready),
		.out_hit      (hit),
		.out_distance (distance)
	);

	a_eps_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && paddr[3:2] == REG_EPS |=> eps_q == $past(pwdata))
		else $error("epsilon register missed a write");

	a_dirx_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && paddr[3:2] == REG_DIR_X |=> dir_q[0] == $past(pwdata))
		else $error("direction x register missed a write");

endmodule

// File: sim/rti_checker.sv
// Checker for the ray/triangle intersection block: snoops the APB writes, the item and the
// result channels, predicts each result and compares it. Depends on rti_pkg.
module rti_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic                       item_ready,
	input  logic [11:0][31:0]          item_bus,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  logic                       hit,
	input  logic [rti_pkg::DISTW-1:0]  distance,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rti_pkg::AW-1:0]     paddr,
	input  logic [31:0]                pwdata,
	output int                         fails,
	output int                         pending
);
	import rti_pkg::*;

	typedef logic signed [255:0] wide_t;
	typedef struct packed {
		logic             hit;
		logic [DISTW-1:0] distance;
	} hit_t;

	logic [31:0] dir_reg [3];
	logic [31:0] eps_reg;
	hit_t        hits_due [$];

	function automatic wide_t sx(logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	// Exact Moller-Trumbore: all products kept at full width, the tests done on
	// the numerators against the determinant.
	function automatic hit_t predict_hit(logic [11:0][31:0] it);
		wide_t p [4][3];
		wide_t d [3];
		wide_t e1 [3];
		wide_t e2 [3];
		wide_t s [3];
		wide_t q [3];
		wide_t r [3];
		wide_t a, nu, nv, nt, num;
		hit_t  res;
		res = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 3; j++)
				p[i][j] = sx(it[i*3+j]);
		for (int j = 0; j < 3; j++) begin
			d[j]  = sx(dir_reg[j]);
			e1[j] = p[2][j] - p[1][j];
			e2[j] = p[3][j] - p[1][j];
			s[j]  = p[0][j] - p[1][j];
		end
		q[0] = d[1]*e2[2] - d[2]*e2[1];
		q[1] = d[2]*e2[0] - d[0]*e2[2];
		q[2] = d[0]*e2[1] - d[1]*e2[0];
		r[0] = s[1]*e1[2] - s[2]*e1[1];
		r[1] = s[2]*e1[0] - s[0]*e1[2];
		r[2] = s[0]*e1[1] - s[1]*e1[0];
		a  = e1[0]*q[0] + e1[1]*q[1] + e1[2]*q[2];
		nu = s[0]*q[0] + s[1]*q[1] + s[2]*q[2];
		nv = d[0]*r[0] + d[1]*r[1] + d[2]*r[2];
		nt = e2[0]*r[0] + e2[1]*r[1] + e2[2]*r[2];
		if (a < 0) begin
			a  = -a;
			nu = -nu;
			nv = -nv;
			nt = -nt;
		end
		if (a == 0 || a < wide_t'({1'b0, eps_reg}))
			return res;
		if (nu < 0 || nv < 0 || nu + nv > a || nt <= 0)
			return res;
		num = nt <<< FRAC;
		res.hit = 1'b1;
		if (num >= (a <<< DISTW))
			res.distance = DIST_MAX;
		else
			res.distance = DISTW'(num / a);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_t want;
		if (!arst_n) begin
			dir_reg[0] = 32'd655360;
			dir_reg[1] = 32'd0;
			dir_reg[2] = 32'd0;
			eps_reg    = 32'd281474977;
			fails      = 0;
			hits_due.delete();
			pending    = 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_DIR_X: dir_reg[0] = pwdata;
					REG_DIR_Y: dir_reg[1] = pwdata;
					REG_DIR_Z: dir_reg[2] = pwdata;
					REG_EPS:   eps_reg    = pwdata;
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				hits_due = {hits_due, predict_hit(item_bus)};
			if (result_valid && result_ready) begin
				if (hits_due.size() == 0) begin
					$error("result transaction with nothing expected");
					fails++;
				end else begin
					want = hits_due.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						fails++;
					end
					if (distance !== want.distance) begin
						$error("distance: expected %0d, got %0d", want.distance, distance);
						fails++;
					end
				end
			end
			pending = hits_due.size();
		end
	end
endmodule

// File: sim/tb_ray_triangle_intersection.sv
// Testbench top for ray_triangle_intersection: clock, reset, APB setup, directed and
// random ray/triangle stimulus and the verdict. Depends on rti_pkg and rti_checker.
module tb_ray_triangle_intersection;
	import rti_pkg::*;

	localparam logic [31:0] U = 32'h0001_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [11:0][31:0] item_bus = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic hit;
	logic [DISTW-1:0] distance;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fails, pending;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	logic [31:0] dir_now [3];

	always #5 clk = ~clk;

	ray_triangle_intersection u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.origin_x(item_bus[0]), .origin_y(item_bus[1]), .origin_z(item_bus[2]),
		.first_x(item_bus[3]), .first_y(item_bus[4]), .first_z(item_bus[5]),
		.second_x(item_bus[6]), .second_y(item_bus[7]), .second_z(item_bus[8]),
		.third_x(item_bus[9]), .third_y(item_bus[10]), .third_z(item_bus[11]),
		.result_valid(result_valid), .result_ready(result_ready),
		.hit(hit), .distance(distance),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rti_checker u_checker (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_ready(item_ready),
		.item_bus(item_bus), .result_valid(result_valid), .result_ready(result_ready),
		.hit(hit), .distance(distance), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
	);

	// Receiver: random stalls, plus a long hold-off on request so the pipeline fills up.
	always @(negedge clk) begin
		static int hold_cnt = 0;
		static int hold_seen = 0;
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ready = 1'b0;
		end else begin
			result_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("tb_ray_triangle_intersection NOT OK");
		$finish;
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = AW'({idx, 2'b00}); pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic set_config(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
			logic [31:0] eps);
		wait (pending == 0);
		repeat (45) @(negedge clk);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_EPS, eps);
		dir_now[0] = dx; dir_now[1] = dy; dir_now[2] = dz;
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(logic [11:0][31:0] it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_bus = it;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	function automatic logic [11:0][31:0] tri_item(logic [31:0] o [3], logic [31:0] v1 [3],
			logic [31:0] v2 [3], logic [31:0] v3 [3]);
		logic [11:0][31:0] it;
		for (int j = 0; j < 3; j++) begin
			it[j] = o[j]; it[3+j] = v1[j]; it[6+j] = v2[j]; it[9+j] = v3[j];
		end
		return it;
	endfunction

	// Mostly triangles around a center with the origin set back along the ray,
	// the rest raw 32-bit noise or small scattered points.
	function automatic logic [11:0][31:0] random_item();
		logic [11:0][31:0] it;
		logic [31:0] cen [3];
		int unsigned sel, range_w, sh;
		sel = $urandom_range(99);
		range_w = 1 << $urandom_range(8, 24);
		sh = $urandom_range(0, 6);
		for (int j = 0; j < 3; j++)
			cen[j] = $urandom_range(0, 2*range_w) - range_w;
		for (int k = 0; k < 12; k++) begin
			if (sel < 25)
				it[k] = $urandom();
			else if (sel < 40)
				it[k] = $urandom_range(0, 2*range_w) - range_w;
			else
				it[k] = cen[k%3] + $urandom_range(0, 2*range_w) - range_w;
		end
		if (sel >= 40)
			for (int j = 0; j < 3; j++)
				it[j] = cen[j] + ($urandom_range(0, range_w/4)) -
					($signed(dir_now[j]) >>> sh);
		return it;
	endfunction

	initial begin
		logic [31:0] o [3], v1 [3], v2 [3], v3 [3];
		logic [11:0][31:0] it;
		dir_now[0] = 32'd655360; dir_now[1] = 0; dir_now[2] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: set_config(32'd0, 3*U, 32'hFFFF_8000, 32'd0);
				2: set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
				3: set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0);
				4: set_config($urandom_range(0, 40*U) - 20*U, $urandom_range(0, 40*U) - 20*U,
					$urandom_range(0, 40*U) - 20*U, $urandom_range(0, 32'h3FFF_FFFF));
				5: set_config(32'd1, 32'd0, 32'd0, 32'd0);
				default: ;
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 78; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 78; end
				default: begin send_idle_pct = 37; stall_pct = 37; end
			endcase

			if (ph == 0) begin
				hold_requests++;
				v1 = '{5*U, 0, 0}; v2 = '{5*U, U, 0}; v3 = '{5*U, 0, U};
				o = '{0, U/4, U/4};      send_item(tri_item(o, v1, v2, v3));
				o = '{0, 0, 0};          send_item(tri_item(o, v1, v2, v3));
				o = '{0, U/2, U/2};      send_item(tri_item(o, v1, v2, v3));
				o = '{0, U, 0};          send_item(tri_item(o, v1, v2, v3));
				o = '{0, U, U};          send_item(tri_item(o, v1, v2, v3));
				o = '{0, U/4, U/4};      send_item(tri_item(o, v1, v3, v2));
				o = '{10*U, U/4, U/4};   send_item(tri_item(o, v1, v2, v3));
				o = '{0, 32'hFFFF_C000, U/4}; send_item(tri_item(o, v1, v2, v3));
				// Triangle one step away along x: the distance truncates to zero.
				v1[0] = 1; v2[0] = 1; v3[0] = 1;
				o = '{0, U/4, U/4};      send_item(tri_item(o, v1, v2, v3));
				// Triangle containing the ray direction: zero determinant.
				v1 = '{0, 0, 0}; v2 = '{U, 0, 0}; v3 = '{0, U, 0};
				send_item(tri_item(o, v1, v2, v3));
				send_item('0);
				send_item({12{32'h7FFF_FFFF}});
				send_item({12{32'h8000_0000}});
				send_item({12{32'hFFFF_FFFF}});
				send_item({12{32'h5555_5555}});
				send_item({12{32'hAAAA_AAAA}});
				for (int k = 0; k < 12; k++) begin
					it = '0;
					it[k] = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					send_item(it);
				end
			end
			if (ph == 1 || ph == 3)
				send_item('0);
			if (ph == 5) begin
				// One-step direction: any offset along x of half a unit or more saturates the distance.
				v1 = '{100*U, 0, 0}; v2 = '{100*U, U, 0}; v3 = '{100*U, 0, U};
				o = '{0, U/4, U/4};
				send_item(tri_item(o, v1, v2, v3));
			end
			for (int n = 0; n < 175; n++)
				send_item(random_item());
			item_valid = 1'b0;
		end

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("tb_ray_triangle_intersection OK");
		else
			$display("tb_ray_triangle_intersection NOT OK");
		$finish;
	end
endmodule

// File: sim.f
rtl/rti_pkg.sv
rtl/rti_front.sv
rtl/rti_dot.sv
rtl/rti_div_step.sv
rtl/rti_test.sv
rtl/ray_triangle_intersection.sv
sim/rti_checker.sv
sim/tb_ray_triangle_intersection.sv
